FILE: rtl/core/tdx_pkg.sv
// Shared types, widths and character codes for the tab expander.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tdx_pkg;

    localparam int NUM_STOPS_DEF   = 6;
    localparam int COLUMN_BITS_DEF = 12;

    localparam int BYTE_W      = 8;
    localparam int STOP_W      = 12;
    localparam int REP_W       = 12;
    localparam int CNT_W       = 3;
    localparam int WIDTH_W     = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

    localparam logic [WIDTH_W-1:0] DEFAULT_TAB = 7'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WIDTH = 3'd7;

    typedef enum logic [1:0] {
        K_PLAIN,
        K_NEWLINE,
        K_TAB
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] ch;
    } t_item;

    typedef enum logic {
        B_IDLE,
        B_DIV
    } t_back_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: rtl/core/tab_expander_with_stops.sv
// Top level of the tab expander with programmable stops.
// Instantiates tdx_front and tdx_back; uses tdx_pkg.
`default_nettype none

// One text byte in, one result out: the byte with repeat count 1, or for a
// tab a space with the run length that reaches the next enabled stop, or the
// next multiple of default_width beyond the last enabled stop. A byte other
// than a tab, and a tab that lands on a stop, streams at one per cycle while
// the output is not stalled. A tab resolved by the default width waits on the
// serial remainder unit, which works through one column bit a cycle. A
// two-entry queue keeps input acceptance going while the back end works; a
// stalled result holds in the result register and blocks new results. Registers
// are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.

module tab_expander_with_stops #(
    parameter int NUM_STOPS   = tdx_pkg::NUM_STOPS_DEF,
    parameter int COLUMN_BITS = tdx_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tdx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tdx_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [tdx_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [tdx_pkg::OUT_TDATA_W-1:0]        m_axis_tdata    // [7:0] out_byte, [19:8] repeat_count
);

    logic           w_q_valid;
    tdx_pkg::t_item w_q_item;
    logic           w_q_pop;

    tdx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    tdx_back #(
        .NUM_STOPS   (NUM_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/tdx_front.sv
// Input side: accepts text bytes, tags each as plain, newline or tab,
// and holds them in a short queue for the back end. Uses tdx_pkg.
`default_nettype none

module tdx_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [tdx_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    output logic                                   o_q_valid,
    output tdx_pkg::t_item                         o_q_item,
    input  wire logic                              i_q_pop
);

    localparam int DEPTH = tdx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tdx_pkg::t_item r_q [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    tdx_pkg::t_item w_item;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_item.ch = s_axis_tdata[tdx_pkg::BYTE_W-1:0];
        if (w_item.ch == tdx_pkg::CH_TAB) begin
            w_item.kind = tdx_pkg::K_TAB;
        end else if (w_item.ch == tdx_pkg::CH_NL) begin
            w_item.kind = tdx_pkg::K_NEWLINE;
        end else begin
            w_item.kind = tdx_pkg::K_PLAIN;
        end
    end

    assign s_axis_tready = (r_count != CNT_W'(DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != '0);
    assign w_pop         = i_q_pop && o_q_valid;
    assign o_q_item      = r_q[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tdx_mod.sv
// Serial remainder unit: column modulo tab width, one dividend bit a cycle.
// Uses tdx_pkg for the width and status types.
`default_nettype none

module tdx_mod #(
    parameter int COLUMN_BITS = tdx_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [COLUMN_BITS-1:0]        i_dividend,
    input  wire logic [tdx_pkg::WIDTH_W-1:0]   i_divisor,
    output logic [tdx_pkg::WIDTH_W-1:0]        o_rem,
    output tdx_pkg::t_div_stat                 o_stat
);

    localparam int W     = tdx_pkg::WIDTH_W;
    localparam int CNT_W = $clog2(COLUMN_BITS + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [COLUMN_BITS-1:0] r_dvd;
    logic [W-1:0]     r_dsr;
    logic [W-1:0]     r_rem;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;

    always_comb begin
        w_trial = {r_rem, r_dvd[COLUMN_BITS-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(COLUMN_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            // restoring step: keep the difference when the trial fits
            r_rem <= (w_trial >= {1'b0, r_dsr}) ? w_diff[W-1:0] : w_trial[W-1:0];
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/tdx_back.sv
// Back end: configuration registers, column tracking, tab stop search,
// run length and the result register. Uses tdx_pkg and tdx_mod.
`default_nettype none

module tdx_back #(
    parameter int NUM_STOPS   = tdx_pkg::NUM_STOPS_DEF,
    parameter int COLUMN_BITS = tdx_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tdx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tdx_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_q_valid,
    input  wire tdx_pkg::t_item                    i_q_item,
    output logic                                   o_q_pop,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [tdx_pkg::OUT_TDATA_W-1:0]        m_axis_tdata  // [7:0] out_byte, [19:8] repeat_count
);

    localparam int SW    = tdx_pkg::STOP_W;
    localparam int RW    = tdx_pkg::REP_W;
    localparam int CW    = tdx_pkg::CNT_W;
    localparam int WW    = tdx_pkg::WIDTH_W;
    localparam int BW    = tdx_pkg::BYTE_W;
    localparam int CMP_W = (COLUMN_BITS > SW) ? COLUMN_BITS : SW;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    // configuration
    logic [CW-1:0] r_stop_count;
    logic [SW-1:0] r_stops [NUM_STOPS];
    logic [WW-1:0] r_dflt_width;

    // datapath state
    tdx_pkg::t_back_state r_state, n_state;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic                   r_out_valid, n_out_valid;
    logic [BW-1:0]          r_out_byte, n_out_byte;
    logic [RW-1:0]          r_out_rep, n_out_rep;

    logic [CW-1:0]  w_enabled;
    logic [SW-1:0]  w_last;
    logic [SW-1:0]  w_target;
    logic           w_stop_path;
    logic [RW-1:0]  w_stop_run;
    logic [WW-1:0]  w_width;
    logic [WW-1:0]  w_rem;
    logic [RW-1:0]  w_dflt_run;
    logic           w_slot_free;
    logic           w_div_start;
    tdx_pkg::t_div_stat w_div_stat;

    function automatic logic [COLUMN_BITS-1:0] col_add(
        input logic [COLUMN_BITS-1:0] c,
        input logic [RW-1:0]          n
    );
        logic [CMP_W:0] s;
        s = (CMP_W+1)'(c) + (CMP_W+1)'(n);
        return (s > (CMP_W+1)'(COL_MAX)) ? COL_MAX : COLUMN_BITS'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= '0;
            r_dflt_width <= tdx_pkg::DEFAULT_TAB;
            for (int i = 0; i < NUM_STOPS; i++) begin
                r_stops[i] <= SW'(i + 1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tdx_pkg::CFG_STOP_COUNT) begin
                r_stop_count <= i_cfg_data[CW-1:0];
            end
            if (i_cfg_idx == tdx_pkg::CFG_DEFAULT_WIDTH) begin
                r_dflt_width <= i_cfg_data[WW-1:0];
            end
            for (int i = 0; i < NUM_STOPS; i++) begin
                if (i_cfg_idx == tdx_pkg::CFG_STOP_FIRST + CW'(i)) begin
                    r_stops[i] <= i_cfg_data[SW-1:0];
                end
            end
        end
    end

    // stop search: last enabled stop, and first enabled stop above the column
    always_comb begin
        w_enabled = (32'(r_stop_count) > NUM_STOPS) ? CW'(NUM_STOPS) : r_stop_count;
        w_last    = '0;
        w_target  = '0;
        for (int i = 0; i < NUM_STOPS; i++) begin
            if (CW'(i) < w_enabled) begin
                w_last = r_stops[i];
            end
        end
        for (int i = NUM_STOPS - 1; i >= 0; i--) begin
            if (CW'(i) < w_enabled && CMP_W'(r_stops[i]) > CMP_W'(r_col)) begin
                w_target = r_stops[i];
            end
        end
        w_stop_path = (w_enabled != '0) && (CMP_W'(r_col) < CMP_W'(w_last));
        w_stop_run  = RW'(CMP_W'(w_target) - CMP_W'(r_col));
        w_width     = (r_dflt_width == '0) ? WW'(1) : r_dflt_width;
        w_dflt_run  = RW'(w_width - w_rem);
    end

    tdx_mod #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_col),
        .i_divisor  (w_width),
        .o_rem      (w_rem),
        .o_stat     (w_div_stat)
    );

    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_rep   = r_out_rep;
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            tdx_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == tdx_pkg::K_TAB && !w_stop_path) begin
                        // run to the next multiple of the width: needs the remainder
                        o_q_pop     = 1'b1;
                        w_div_start = 1'b1;
                        n_state     = tdx_pkg::B_DIV;
                    end else if (w_slot_free) begin
                        o_q_pop     = 1'b1;
                        n_out_valid = 1'b1;
                        unique case (i_q_item.kind)
                            tdx_pkg::K_TAB: begin
                                n_out_byte = tdx_pkg::CH_SPACE;
                                n_out_rep  = w_stop_run;
                                n_col      = col_add(r_col, w_stop_run);
                            end
                            tdx_pkg::K_NEWLINE: begin
                                n_out_byte = i_q_item.ch;
                                n_out_rep  = RW'(1);
                                n_col      = '0;
                            end
                            default: begin
                                n_out_byte = i_q_item.ch;
                                n_out_rep  = RW'(1);
                                n_col      = col_add(r_col, RW'(1));
                            end
                        endcase
                    end
                end
            end
            tdx_pkg::B_DIV: begin
                if (w_div_stat.done && w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = tdx_pkg::CH_SPACE;
                    n_out_rep   = w_dflt_run;
                    n_col       = col_add(r_col, w_dflt_run);
                    n_state     = tdx_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = tdx_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdx_pkg::B_IDLE;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_rep  <= n_out_rep;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(tdx_pkg::OUT_TDATA_W - RW - BW)'(0), r_out_rep, r_out_byte};

endmodule

`default_nettype wire

FILE: rtl/core/tdx_checker.sv
// Port-level checks for the tab expander, bound to the top level.
// Uses tdx_pkg for widths and the space code.
`default_nettype none

module tdx_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [tdx_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_rep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:8] != 12'd0)
        else $error("zero repeat count");

    // only an expanded tab carries a run longer than one
    a_rep_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7:0] != tdx_pkg::CH_SPACE
            |-> m_axis_tdata[19:8] == 12'd1)
        else $error("non-space result with repeat above one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tab_expander_with_stops tdx_checker u_tdx_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for tab_expander_with_stops: text bytes in, byte/run-length out.
// Keeps its own column and tab-stop model to predict each result; needs tdx_pkg and the RTL.

module testbench;
    import tdx_pkg::*;

    localparam int NUM_STOPS     = NUM_STOPS_DEF;
    localparam int COL_MAX       = (1 << COLUMN_BITS_DEF) - 1;
    localparam int SETTLE_CYCLES = COLUMN_BITS_DEF + 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [REP_W-1:0]  reps;
        logic [BYTE_W-1:0] ch;
    } run_t;

    typedef logic [STOP_W-1:0] stop_list_t [NUM_STOPS];

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [7:0] text_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] out_byte, [19:8] repeat_count

    // model of the block's registers and column
    logic [CNT_W-1:0]   stop_cnt;
    logic [STOP_W-1:0]  stop_col [NUM_STOPS];
    logic [WIDTH_W-1:0] dflt_width;
    int unsigned        col_now;

    run_t        pending_runs [$];
    int unsigned mismatches = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    stop_list_t  rnd_stops;

    tab_expander_with_stops DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_asked != hold_taken) begin
            hold_taken    <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        run_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_runs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_runs.pop_front();
                if (m_axis_tdata[7:0] !== want.ch) begin
                    mismatches++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.ch, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[19:8] !== want.reps) begin
                    mismatches++;
                    $display("%0t: repeat_count expected %0d actual %0d",
                             $time, want.reps, m_axis_tdata[19:8]);
                end
            end
        end
    end

    function automatic int unsigned col_sat(input int unsigned c);
        return (c > COL_MAX) ? COL_MAX : c;
    endfunction

    // expected run for one accepted byte; advances the column
    function automatic void predict_run(input logic [BYTE_W-1:0] b);
        run_t        r;
        int          lim;
        int unsigned tgt;
        int unsigned span;
        int unsigned w;
        lim = (stop_cnt > NUM_STOPS) ? NUM_STOPS : int'(stop_cnt);
        if (b != CH_TAB) begin
            r.ch    = b;
            r.reps  = REP_W'(1);
            col_now = (b == CH_NL) ? 0 : col_sat(col_now + 1);
        end else begin
            if (lim > 0 && col_now < stop_col[lim-1]) begin
                tgt = 32'(stop_col[lim-1]);
                // walk down so the lowest-index stop above the column wins
                for (int i = lim - 1; i >= 0; i--)
                    if (stop_col[i] > col_now) tgt = 32'(stop_col[i]);
                span = tgt - col_now;
            end else begin
                w    = (dflt_width == 0) ? 1 : 32'(dflt_width);
                span = w - (col_now % w);
            end
            r.ch    = CH_SPACE;
            r.reps  = span[REP_W-1:0];
            col_now = col_sat(col_now + span);
        end
        pending_runs.push_back(r);
    endfunction

    task automatic send_text(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom_range(255));
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_run(b);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_text(s[i]);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_STOP_COUNT)
            stop_cnt = data[CNT_W-1:0];
        else if (idx == CFG_DEFAULT_WIDTH)
            dflt_width = data[WIDTH_W-1:0];
        else
            stop_col[idx - CFG_STOP_FIRST] = data[STOP_W-1:0];
    endtask

    task automatic set_layout(input logic [CNT_W-1:0] cnt, input logic [WIDTH_W-1:0] w,
                              input stop_list_t s);
        wait_idle();
        write_reg(CFG_STOP_COUNT, CFG_DATA_W'(cnt));
        for (int i = 0; i < NUM_STOPS; i++)
            write_reg(CFG_IDX_W'(int'(CFG_STOP_FIRST) + i), CFG_DATA_W'(s[i]));
        write_reg(CFG_DEFAULT_WIDTH, CFG_DATA_W'(w));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_layout();
        int unsigned       pos;
        logic [WIDTH_W-1:0] w;
        int unsigned       pick;
        pos = $urandom_range(1, 12);
        for (int i = 0; i < NUM_STOPS; i++) begin
            // mostly increasing stops, sometimes anything the field holds
            rnd_stops[i] = ($urandom_range(99) < 15) ? STOP_W'($urandom_range(4095))
                                                      : STOP_W'(pos);
            pos = pos + $urandom_range(1, 25);
        end
        pick = $urandom_range(99);
        if (pick < 80)      w = WIDTH_W'($urandom_range(1, 64));
        else if (pick < 90) w = '0;
        else                w = WIDTH_W'($urandom_range(65, 127));
        set_layout(CNT_W'($urandom_range(7)), w, rnd_stops);
    endtask

    task automatic send_random_text(input int n);
        int unsigned r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 35)      send_text(CH_TAB);
            else if (r < 42) send_text(CH_NL);
            else             send_text(BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic test_default_spacing();
        send_text(8'h00);
        send_text(8'hFF);
        send_string("ab");
        send_text(CH_TAB);
        send_text(CH_TAB);
        send_text(CH_NL);
        send_text(CH_TAB);
        send_text(8'h7F);
        send_text(CH_TAB);
    endtask

    task automatic test_stop_layouts();
        set_layout(3'd3, 7'd8, '{12'd4, 12'd10, 12'd20, 12'd30, 12'd40, 12'd50});
        send_text(CH_NL);
        send_text(CH_TAB);
        send_text(CH_TAB);
        send_text("a");
        send_text(CH_TAB);
        send_text(CH_TAB);   // past the last stop, default width takes over
    endtask

    task automatic test_odd_stops();
        // count above the register file, a zero stop, stops out of order, zero width
        set_layout(3'd7, 7'd0, '{12'd0, 12'd30, 12'd12, 12'd40, 12'd41, 12'd60});
        send_text(CH_NL);
        send_text(CH_TAB);
        send_text(CH_TAB);
        send_string("xy");
        send_text(CH_TAB);
        send_text(CH_TAB);
    endtask

    task automatic test_column_saturation();
        set_layout(3'd1, 7'd64, '{12'd4095, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1});
        send_text(CH_NL);
        send_text(CH_TAB);
        send_text(CH_TAB);   // column pinned at its maximum
        send_text("z");
        send_text(CH_NL);
        send_text("q");
        send_text(CH_TAB);
    endtask

    task automatic test_random_text();
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_gap_pct = 25; recv_gap_pct = 69; end
                1: begin send_gap_pct = 69; recv_gap_pct = 25; end
                default: begin send_gap_pct = 0; recv_gap_pct = 0; end
            endcase
            for (int k = 0; k < 3; k++) begin
                random_layout();
                send_random_text(50);
            end
        end
    endtask

    task automatic test_backpressure();
        random_layout();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_asked++;
        send_random_text(30);
    endtask

    initial begin
        stop_cnt   = '0;
        for (int i = 0; i < NUM_STOPS; i++) stop_col[i] = STOP_W'(i + 1);
        dflt_width = DEFAULT_TAB;
        col_now    = 0;
        send_gap_pct = 25;
        recv_gap_pct = 69;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_spacing();
        test_stop_layouts();
        test_odd_stops();
        test_column_saturation();
        test_random_text();
        test_backpressure();

        wait_idle();
        if (mismatches == 0 && pending_runs.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
